### hw/rtl/date_add_signed_days_top_macros.svh
// assertion macros shared by the date adder checks
`ifndef DATE_ADD_SIGNED_DAYS_TOP_MACROS_SVH
`define DATE_ADD_SIGNED_DAYS_TOP_MACROS_SVH

// property that holds at every clock edge outside reset
`define DASD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define DASD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/dasd_pkg.sv
// types, constants and calendar tables for the date adder
package dasd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 22;
    localparam int YDAYS_W  = 23;
    localparam int MDAYS_W  = 9;
    localparam int Q_W      = 8;

    localparam logic [SERIAL_W-1:0] DAYS_400Y   = 22'd146097;
    localparam logic [SERIAL_W-1:0] DAYS_100Y   = 22'd36524;
    localparam logic [SERIAL_W-1:0] DAYS_4Y     = 22'd1461;
    localparam logic [SERIAL_W-1:0] DAYS_1Y     = 22'd365;
    localparam logic [SERIAL_W-1:0] SERIAL_LAST = 22'd3652058;

    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [MONTH_W-1:0] FEB       = 4'd2;

    localparam logic [2:0] PH_400 = 3'd0;
    localparam logic [2:0] PH_100 = 3'd1;
    localparam logic [2:0] PH_4   = 3'd2;
    localparam logic [2:0] PH_1   = 3'd3;
    localparam logic [2:0] PH_MON = 3'd4;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       ydays;
        logic       sum;
        logic       check;
        logic       step;
        logic [2:0] phase;
        logic       out_load;
    } dasd_cmd_t;

    typedef struct packed {
        logic flag;
        logic step_ok;
        logic out_free;
    } dasd_status_t;

    function automatic logic [MDAYS_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [MDAYS_W-1:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m) inside
            4'd2:                       d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
            default:                    d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/date_add_signed_days_top.sv
// the MUL, YDAYS, SUM and CHECK states build the day count and check the range, then one
// subtract-and-compare per cycle peels off 400-year, 100-year, 4-year, 1-year and month
// steps; a refused date skips the steps and returns the input date with out_of_range set
// one transaction at a time: s_tready returns the cycle after the result is loaded, and
// the controller waits in the done state while a stalled result holds the output register
// aresetn (synchronous, active low) returns the controller to idle and clears m_tvalid
module date_add_signed_days_top
    import dasd_pkg::*;
#(
    parameter int OFFSET_WIDTH = 21
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // year[13:0], month[17:14], day[22:18], day_offset, zero pad
    input  logic [((23+OFFSET_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18], zero pad
    output logic [23:0]                      m_tdata,
    // out_of_range
    output logic [0:0]                       m_tuser
);

    localparam int OFF_LSB = YEAR_W + MONTH_W + DAY_W;

    dasd_cmd_t    cmd;
    dasd_status_t st;

    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic               out_of_range;

    dasd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dasd_datapath #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_year      (s_tdata[YEAR_W-1:0]),
        .in_month     (s_tdata[YEAR_W +: MONTH_W]),
        .in_day       (s_tdata[YEAR_W+MONTH_W +: DAY_W]),
        .in_offset    ($signed(s_tdata[OFF_LSB +: OFFSET_WIDTH])),
        .cmd          (cmd),
        .st           (st),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .out_of_range (out_of_range)
    );

    assign m_tdata = {1'b0, result_day, result_month, result_year};
    assign m_tuser = out_of_range;

endmodule

### hw/rtl/dasd_ctrl.sv
// controller sequencing the day count build and the subtract-and-count loops
module dasd_ctrl
    import dasd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  dasd_status_t st,
    output dasd_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_YDAYS = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_P400  = 4'd5;
    localparam logic [3:0] S_P100  = 4'd6;
    localparam logic [3:0] S_P4    = 4'd7;
    localparam logic [3:0] S_P1    = 4'd8;
    localparam logic [3:0] S_PMON  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.phase  = PH_400;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_YDAYS;
            end
            S_YDAYS: begin
                cmd.ydays  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_P400;
            end
            S_P400: begin
                cmd.phase = PH_400;
                if (st.flag) begin
                    state_next = S_DONE;
                end else if (st.step_ok) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = S_P100;
                end
            end
            S_P100: begin
                cmd.phase = PH_100;
                if (st.step_ok) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = S_P4;
                end
            end
            S_P4: begin
                cmd.phase = PH_4;
                if (st.step_ok) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = S_P1;
                end
            end
            S_P1: begin
                cmd.phase = PH_1;
                if (st.step_ok) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = S_PMON;
                end
            end
            S_PMON: begin
                cmd.phase = PH_MON;
                if (st.step_ok) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/dasd_datapath.sv
// datapath: day count from the input date, then peel it back into a date
module dasd_datapath
    import dasd_pkg::*;
#(
    parameter int OFFSET_WIDTH = 21
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [YEAR_W-1:0]              in_year,
    input  logic [MONTH_W-1:0]             in_month,
    input  logic [DAY_W-1:0]               in_day,
    input  logic signed [OFFSET_WIDTH-1:0] in_offset,
    input  dasd_cmd_t                      cmd,
    output dasd_status_t                   st,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [YEAR_W-1:0]              result_year,
    output logic [MONTH_W-1:0]             result_month,
    output logic [DAY_W-1:0]               result_day,
    output logic                           out_of_range
);

    localparam int SUM_W = ((OFFSET_WIDTH > YDAYS_W) ? OFFSET_WIDTH : YDAYS_W) + 2;

    logic [YEAR_W-1:0]              year_in_reg;
    logic [MONTH_W-1:0]             month_in_reg;
    logic [DAY_W-1:0]               day_in_reg;
    logic signed [OFFSET_WIDTH-1:0] off_reg;
    logic                           in_ok_reg;
    logic [Q_W-1:0]                 q_reg;
    logic [YDAYS_W-1:0]             ydays_reg;
    logic [MDAYS_W-1:0]             mdays_reg;
    logic [SUM_W-1:0]               s_reg;
    logic [SERIAL_W-1:0]            r_reg;
    logic [YEAR_W-1:0]              yacc_reg;
    logic [1:0]                     n100_reg;
    logic [4:0]                     n4_reg;
    logic [1:0]                     n1_reg;
    logic [MONTH_W-1:0]             mon_reg;
    logic                           flag_reg;
    logic                           m_tvalid_reg;
    logic [YEAR_W-1:0]              res_year_reg;
    logic [MONTH_W-1:0]             res_month_reg;
    logic [DAY_W-1:0]               res_day_reg;
    logic                           res_flag_reg;

    logic [YEAR_W-1:0]   p;
    logic [26:0]         prod;
    logic [YEAR_W-1:0]   rem;
    logic                leap_in;
    logic [YDAYS_W-1:0]  ydays_next;
    logic [MDAYS_W-1:0]  mdays_next;
    logic [SUM_W-1:0]    s_next;
    logic                in_range;
    logic                leap_res;
    logic [SERIAL_W-1:0] step_amt;
    logic                step_lim;

    assign p    = year_in_reg - 14'd1;
    assign prod = 27'(p) * 27'(RECIP_100);
    assign rem  = p - 14'(q_reg) * 14'd100;

    assign leap_in = ((p[1:0] == 2'd3) && (rem != 14'd99))
                   || ((rem == 14'd99) && (q_reg[1:0] == 2'd3));

    assign ydays_next = 23'(p) * 23'd365 + 23'(p >> 2) - 23'(q_reg) + 23'(q_reg >> 2);
    assign mdays_next = cum_days(month_in_reg)
                      + 9'((month_in_reg > FEB) && leap_in);

    assign s_next = SUM_W'(ydays_reg) + SUM_W'(mdays_reg) + SUM_W'(day_in_reg)
                  - SUM_W'(1) + SUM_W'(off_reg);

    assign in_range = in_ok_reg && !s_reg[SUM_W-1] && (s_reg <= SUM_W'(SERIAL_LAST));

    assign leap_res = (n1_reg == 2'd3) && ((n4_reg != 5'd24) || (n100_reg == 2'd3));

    always_comb begin
        unique case (cmd.phase)
            PH_400: begin
                step_amt = DAYS_400Y;
                step_lim = 1'b1;
            end
            PH_100: begin
                step_amt = DAYS_100Y;
                step_lim = (n100_reg != 2'd3);
            end
            PH_4: begin
                step_amt = DAYS_4Y;
                step_lim = 1'b1;
            end
            PH_1: begin
                step_amt = DAYS_1Y;
                step_lim = (n1_reg != 2'd3);
            end
            PH_MON: begin
                step_amt = 22'(month_days(mon_reg, leap_res));
                step_lim = (mon_reg < MONTH_MAX);
            end
            default: begin
                step_amt = DAYS_1Y;
                step_lim = 1'b0;
            end
        endcase
    end

    assign st.flag     = flag_reg;
    assign st.step_ok  = step_lim && (r_reg >= step_amt);
    assign st.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            year_in_reg  <= in_year;
            month_in_reg <= in_month;
            day_in_reg   <= in_day;
            off_reg      <= in_offset;
            in_ok_reg    <= (in_year >= 14'd1) && (in_year <= YEAR_MAX)
                         && (in_month >= 4'd1) && (in_month <= MONTH_MAX);
        end
        if (cmd.mul) begin
            q_reg <= prod[RECIP_SHIFT +: Q_W];
        end
        if (cmd.ydays) begin
            ydays_reg <= ydays_next;
            mdays_reg <= mdays_next;
        end
        if (cmd.sum) begin
            s_reg <= s_next;
        end
        if (cmd.check) begin
            flag_reg <= !in_range;
            r_reg    <= s_reg[SERIAL_W-1:0];
            yacc_reg <= 14'd1;
            n100_reg <= 2'd0;
            n4_reg   <= 5'd0;
            n1_reg   <= 2'd0;
            mon_reg  <= 4'd1;
        end
        if (cmd.step) begin
            r_reg <= r_reg - step_amt;
            unique case (cmd.phase)
                PH_400: yacc_reg <= yacc_reg + 14'd400;
                PH_100: begin
                    yacc_reg <= yacc_reg + 14'd100;
                    n100_reg <= n100_reg + 2'd1;
                end
                PH_4: begin
                    yacc_reg <= yacc_reg + 14'd4;
                    n4_reg   <= n4_reg + 5'd1;
                end
                PH_1: begin
                    yacc_reg <= yacc_reg + 14'd1;
                    n1_reg   <= n1_reg + 2'd1;
                end
                PH_MON:  mon_reg <= mon_reg + 4'd1;
                default: mon_reg <= mon_reg;
            endcase
        end
        if (cmd.out_load) begin
            res_flag_reg <= flag_reg;
            if (flag_reg) begin
                res_year_reg  <= year_in_reg;
                res_month_reg <= month_in_reg;
                res_day_reg   <= day_in_reg;
            end else begin
                res_year_reg  <= yacc_reg;
                res_month_reg <= mon_reg;
                res_day_reg   <= r_reg[DAY_W-1:0] + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign result_year  = res_year_reg;
    assign result_month = res_month_reg;
    assign result_day   = res_day_reg;
    assign out_of_range = res_flag_reg;

endmodule

### hw/rtl/dasd_checker.sv
// port-level checks for the date adder, bound to the top level
`include "date_add_signed_days_top_macros.svh"

module dasd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic        stalled;
    logic [24:0] m_word;
    logic        date_ok;

    assign stalled = m_tvalid && !m_tready;
    assign m_word  = {m_tuser, m_tdata};
    assign date_ok = (m_tdata[13:0] >= 14'd1) && (m_tdata[13:0] <= 14'd9999)
                  && (m_tdata[17:14] >= 4'd1) && (m_tdata[17:14] <= 4'd12)
                  && (m_tdata[22:18] >= 5'd1);

    `DASD_ASSERT_NEXT(a_out_valid_holds, stalled, m_tvalid, "m_tvalid dropped")
    `DASD_ASSERT_NEXT(a_out_data_holds, stalled, $stable(m_word), "stalled result changed")
    `DASD_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second transaction taken")
    `DASD_ASSERT(a_valid_date, !m_tvalid || m_tuser[0] || date_ok, "result is not a valid date")

endmodule

bind date_add_signed_days_top dasd_checker u_dasd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/date_add_signed_days_top_tb.sv
// self-checking testbench for the signed day-offset date adder
module date_add_signed_days_top_tb
    import dasd_pkg::*;
();

    localparam int OFS_W = 21;
    localparam int S_W   = ((23 + OFS_W + 7) / 8) * 8;

    localparam int PHASE_DIRECTED   = 0;
    localparam int PHASE_FREE       = 1;
    localparam int PHASE_SEND_IDLE  = 2;
    localparam int PHASE_RECV_STALL = 3;
    localparam int PHASE_BOTH_IDLE  = 4;

    localparam int ITEMS_PER_PHASE = 20;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 100;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               out_of_range;
    } date_result_t;

    class date_scoreboard;
        date_result_t pending_dates[$];
        int mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function bit leap_year(longint y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function longint month_length(longint y, int m);
            case (m) inside
                2:           return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // days from 0001-01-01 to the first of month m of year y
        function longint day_number(longint y, int m);
            longint p;
            longint n;
            p = y - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400;
            for (int k = 1; k < m; k++)
                n += month_length(y, k);
            return n;
        endfunction

        function date_result_t shifted_date(logic [S_W-1:0] item);
            date_result_t res;
            longint y;
            longint dd;
            longint ofs;
            longint n;
            longint r;
            longint q400;
            longint q100;
            longint q4;
            longint q1;
            int m;
            y   = item[13:0];
            m   = item[17:14];
            dd  = item[22:18];
            ofs = $signed(item[23 +: OFS_W]);
            res.year         = item[13:0];
            res.month        = item[17:14];
            res.day          = item[22:18];
            res.out_of_range = 1'b1;
            if (y >= 1 && y <= 9999 && m >= 1 && m <= 12) begin
                n = day_number(y, m) + dd - 1 + ofs;
                if (n >= 0 && n <= day_number(9999, 12) + 30) begin
                    q400 = n / 146097;
                    r    = n % 146097;
                    q100 = r / 36524;
                    if (q100 > 3) q100 = 3;
                    r    = r - q100 * 36524;
                    q4   = r / 1461;
                    r    = r - q4 * 1461;
                    q1   = r / 365;
                    if (q1 > 3) q1 = 3;
                    r    = r - q1 * 365;
                    y    = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
                    m    = 1;
                    while (m < 12 && r >= month_length(y, m)) begin
                        r = r - month_length(y, m);
                        m++;
                    end
                    res.year         = y[YEAR_W-1:0];
                    res.month        = m[MONTH_W-1:0];
                    res.day          = r[DAY_W-1:0] + 5'd1;
                    res.out_of_range = 1'b0;
                end
            end
            return res;
        endfunction

        function void note_accepted(logic [S_W-1:0] item);
            pending_dates.push_back(shifted_date(item));
        endfunction

        function int pending();
            return pending_dates.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(logic [23:0] tdata, logic [0:0] tuser);
            date_result_t exp;
            if (pending_dates.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction %h/%b", tdata, tuser));
            end else begin
                exp = pending_dates.pop_front();
                if (tdata[13:0] !== exp.year || tdata[17:14] !== exp.month ||
                    tdata[22:18] !== exp.day || tuser[0] !== exp.out_of_range)
                    report_mismatch($sformatf(
                        "got %0d-%0d-%0d oor=%b, expected %0d-%0d-%0d oor=%b",
                        tdata[13:0], tdata[17:14], tdata[22:18], tuser[0],
                        exp.year, exp.month, exp.day, exp.out_of_range));
            end
        endtask
    endclass

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [23:0]    m_tdata;
    logic [0:0]     m_tuser;

    date_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int phase_id;

    date_add_signed_days_top #(
        .OFFSET_WIDTH(OFS_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [S_W-1:0] date_item(int y, int m, int d, int ofs);
        logic [13:0]      yy;
        logic [3:0]       mm;
        logic [4:0]       dd;
        logic [OFS_W-1:0] oo;
        yy = y[13:0];
        mm = m[3:0];
        dd = d[4:0];
        oo = ofs[OFS_W-1:0];
        return {{(S_W - 23 - OFS_W){1'b0}}, oo, dd, mm, yy};
    endfunction

    task automatic random_date(output logic [S_W-1:0] item);
        int y;
        int m;
        int d;
        int ofs;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            y = $urandom_range(0, 16383);
        else if (pick < 16)
            y = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
        else
            y = $urandom_range(1, 9999);
        m = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        d = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 28) : $urandom_range(0, 31);
        case ($urandom_range(0, 3))
            0:       ofs = $signed($urandom_range(0, 800)) - 400;
            1:       ofs = $signed($urandom_range(0, 80000)) - 40000;
            2:       ofs = $urandom;
            default: ofs = $signed($urandom_range(0, 3000)) - 1500;
        endcase
        item = date_item(y, m, d, ofs);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_date(input logic [S_W-1:0] item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = item;
        do @(posedge aclk); while (!s_tready);
        sb.note_accepted(item);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // receiver side, with one long hold-off so the block backs up
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (phase_id == PHASE_RECV_STALL && !held) begin
                hold_left = LONG_HOLD;
                held      = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        logic [S_W-1:0] item;
        sb             = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        phase_id       = PHASE_DIRECTED;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        send_date(date_item(2000, 2, 28, 1));
        send_date(date_item(1900, 2, 28, 1));
        send_date(date_item(2100, 3, 1, -1));
        send_date(date_item(2400, 3, 1, -1));
        send_date(date_item(2000, 4, 30, 1));
        send_date(date_item(2024, 12, 31, 1));
        send_date(date_item(1, 1, 1, 0));
        send_date(date_item(1, 1, 1, -1));
        send_date(date_item(9999, 12, 31, 0));
        send_date(date_item(9999, 12, 31, 1));
        send_date(date_item(1, 1, 1, 1048575));
        send_date(date_item(9999, 12, 31, -1048576));
        send_date(date_item(2000, 6, 15, -1048576));
        send_date(date_item(0, 6, 15, 10));
        send_date(date_item(10000, 1, 1, -5));
        send_date(date_item(16383, 15, 31, -1));
        send_date(date_item(2020, 0, 10, 3));
        send_date(date_item(2020, 13, 10, 3));
        send_date(date_item(2023, 3, 0, 0));
        send_date(date_item(2023, 4, 31, 0));
        send_date(date_item(2024, 2, 31, 0));
        send_date(date_item(8192, 8, 31, -1));
        send_date(date_item(1, 3, 1, -60));

        for (int ph = PHASE_FREE; ph <= PHASE_BOTH_IDLE; ph++) begin
            case (ph)
                PHASE_SEND_IDLE:  begin send_idle_pct = 61; recv_stall_pct = 0;  end
                PHASE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                PHASE_BOTH_IDLE:  begin send_idle_pct = 18; recv_stall_pct = 18; end
                default:          begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            phase_id = ph;
            repeat (ITEMS_PER_PHASE) begin
                random_date(item);
                send_date(item);
            end
        end
        s_tvalid = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatch_count == 0)
            $display("date_add_signed_days_top_tb: PASS");
        else
            $display("date_add_signed_days_top_tb: FAIL");
        $finish;
    end

    initial begin
        #800000;
        $display("date_add_signed_days_top_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/dasd_pkg.sv
hw/rtl/dasd_ctrl.sv
hw/rtl/dasd_datapath.sv
hw/rtl/date_add_signed_days_top.sv
hw/rtl/dasd_checker.sv
dv/date_add_signed_days_top_tb.sv
